### design/lfu_cache_table_unit_macros.svh
// assertion macros for the lfu cache table
`ifndef LFU_CACHE_TABLE_UNIT_MACROS_SVH
`define LFU_CACHE_TABLE_UNIT_MACROS_SVH
`ifndef SYNTH
`define LFU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("lfu assertion failed");
`define LFU_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) else $error("lfu reset assertion failed");
`else
`define LFU_ASSERT(lbl, prop)
`define LFU_ASSERT_RST(lbl, prop)
`endif
`endif

### design/lfu_pkg.sv
// shared types and constants of the lfu cache table
`timescale 1ns / 1ps
package lfu_pkg;
    localparam int DEPTH = 16;
    localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int CAPW = 5;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    typedef struct packed {
        logic               action;
        logic signed [31:0] lookup_key;
        logic signed [31:0] put_value;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic signed [31:0] read_value;
        logic               evicted;
        logic signed [31:0] evicted_key;
    } t_out_item;

    typedef enum logic [1:0] {
        CELL_IDLE,
        CELL_TOUCH,
        CELL_INSERT,
        CELL_EVICT_INSERT
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [IDXW-1:0]  sel_idx;
        logic [IDXW-1:0]  ref_rank;
        logic             write_value;
        logic [31:0]      key;
        logic [31:0]      value;
    } t_cell_cmd;

    // running victim candidate passed along the chain
    typedef struct packed {
        logic             valid;
        logic [31:0]      count;
        logic [IDXW-1:0]  rank;
        logic [IDXW-1:0]  idx;
        logic [31:0]      key;
    } t_cand;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SCAN,
        ST_EVICT,
        ST_DONE
    } t_state;
endpackage

### design/lfu_cell.sv
// one cache entry with its share of the victim search chain
`timescale 1ns / 1ps
module lfu_cell import lfu_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [IDXW-1:0] i_index,
    input  t_cell_cmd       i_cmd,
    input  logic [31:0]     i_key,
    input  t_cand           i_cand,
    output t_cand           o_cand,
    output logic            o_match,
    output logic            o_valid,
    output logic [IDXW-1:0] o_rank,
    output logic [31:0]     o_value
);
    logic            r_valid, n_valid;
    logic [31:0]     r_key, n_key;
    logic [31:0]     r_value, n_value;
    logic [31:0]     r_count, n_count;
    logic [IDXW-1:0] r_rank, n_rank;
    t_cand           r_cand, n_cand;
    logic            sel;

    assign sel = (i_cmd.sel_idx == i_index);

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_value = r_value;
        n_count = r_count;
        n_rank  = r_rank;
        case (i_cmd.op)
            CELL_TOUCH: begin
                if (sel) begin
                    n_rank = '0;
                    if (r_count != 32'hFFFF_FFFF) n_count = r_count + 32'd1;
                    if (i_cmd.write_value) n_value = i_cmd.value;
                end else if (r_valid && r_rank < i_cmd.ref_rank) begin
                    n_rank = r_rank + 1'b1;
                end
            end
            CELL_INSERT, CELL_EVICT_INSERT: begin
                if (sel) begin
                    n_valid = 1'b1;
                    n_key   = i_cmd.key;
                    n_value = i_cmd.value;
                    n_count = 32'd1;
                    n_rank  = '0;
                end else if (r_valid) begin
                    // entries behind the victim close the gap, then all age by one
                    if (i_cmd.op == CELL_EVICT_INSERT && r_rank > i_cmd.ref_rank)
                        n_rank = r_rank;
                    else
                        n_rank = r_rank + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_cand = i_cand;
        if (r_valid && (!i_cand.valid || r_count < i_cand.count ||
                        (r_count == i_cand.count && r_rank > i_cand.rank))) begin
            n_cand.valid = 1'b1;
            n_cand.count = r_count;
            n_cand.rank  = r_rank;
            n_cand.idx   = i_index;
            n_cand.key   = r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_cand.valid <= 1'b0;
        end else begin
            r_valid      <= n_valid;
            r_cand.valid <= n_cand.valid;
        end
        r_key        <= n_key;
        r_value      <= n_value;
        r_count      <= n_count;
        r_rank       <= n_rank;
        r_cand.count <= n_cand.count;
        r_cand.rank  <= n_cand.rank;
        r_cand.idx   <= n_cand.idx;
        r_cand.key   <= n_cand.key;
    end

    assign o_cand  = r_cand;
    assign o_match = r_valid && (r_key == i_key);
    assign o_valid = r_valid;
    assign o_rank  = r_rank;
    assign o_value = r_value;
endmodule

### design/lfu_cache_table_unit.sv
// lfu cache table: a get or put on a hit, a fill or a capacity-zero put runs through look
// and done; a put that must evict also runs scan and evict (the victim search walks
// the cell chain, one cell a cycle); the next item is taken once the result is in the
// output register.
// reset (synchronous, active low) empties every entry and sets capacity to 16.
`timescale 1ns / 1ps
`include "lfu_cache_table_unit_macros.svh"
module lfu_cache_table_unit import lfu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_state               r_state, n_state;
    t_in_item             r_item;
    t_out_item            r_res, n_res;
    t_out_item            r_out;
    logic                 r_out_valid;
    logic [CAPW-1:0]      r_capacity;
    logic [IDXW-1:0]      r_scan, n_scan;
    t_cell_cmd            cmd;
    t_cand                cand [DEPTH+1];
    logic [DEPTH-1:0]     match_vec, valid_vec;
    logic [IDXW-1:0]      rank_arr  [DEPTH];
    logic [31:0]          value_arr [DEPTH];
    logic [IDXW-1:0]      hit_idx, free_idx, hit_rank;
    logic [31:0]          hit_value;
    logic                 found;
    logic [CNTW-1:0]      fill;
    logic [CAPW-1:0]      cap;
    logic                 out_free;

    assign cand[0] = '0;

    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        lfu_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDXW'(j)),
            .i_cmd   (cmd),
            .i_key   (r_item.lookup_key),
            .i_cand  (cand[j]),
            .o_cand  (cand[j+1]),
            .o_match (match_vec[j]),
            .o_valid (valid_vec[j]),
            .o_rank  (rank_arr[j]),
            .o_value (value_arr[j])
        );
    end

    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int j = 0; j < DEPTH; j++) begin
            if (match_vec[j]) hit_idx = hit_idx | IDXW'(j);
        end
        for (int j = DEPTH - 1; j >= 0; j--) begin
            if (!valid_vec[j]) free_idx = IDXW'(j);
        end
    end

    assign hit_rank  = rank_arr[hit_idx];
    assign hit_value = value_arr[hit_idx];
    assign found     = |match_vec;
    assign fill      = CNTW'($countones(valid_vec));
    assign cap       = (r_capacity > CAPW'(DEPTH)) ? CAPW'(DEPTH) : r_capacity;
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state          = r_state;
        n_res            = r_res;
        n_scan           = r_scan;
        cmd              = '0;
        cmd.op           = CELL_IDLE;
        cmd.key          = r_item.lookup_key;
        cmd.value        = r_item.put_value;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_LOOK;
            end
            ST_LOOK: begin
                n_res       = '0;
                n_res.found = found;
                n_state     = ST_DONE;
                if (r_item.action == ACT_GET) begin
                    n_res.read_value = found ? hit_value : -32'sd1;
                    if (found) begin
                        cmd.op       = CELL_TOUCH;
                        cmd.sel_idx  = hit_idx;
                        cmd.ref_rank = hit_rank;
                    end
                end else if (cap != '0) begin
                    if (found) begin
                        cmd.op          = CELL_TOUCH;
                        cmd.sel_idx     = hit_idx;
                        cmd.ref_rank    = hit_rank;
                        cmd.write_value = 1'b1;
                    end else if (fill < CNTW'(cap)) begin
                        cmd.op      = CELL_INSERT;
                        cmd.sel_idx = free_idx;
                    end else begin
                        n_scan  = '0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // chain must settle through every cell
                n_scan = r_scan + 1'b1;
                if (r_scan == IDXW'(DEPTH - 1)) n_state = ST_EVICT;
            end
            ST_EVICT: begin
                cmd.op            = CELL_EVICT_INSERT;
                cmd.sel_idx       = cand[DEPTH].idx;
                cmd.ref_rank      = cand[DEPTH].rank;
                n_res.evicted     = 1'b1;
                n_res.evicted_key = cand[DEPTH].key;
                n_state           = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_capacity  <= CAPW'(16);
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && out_free) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
            if (psel && penable && pwrite && !paddr[2]) r_capacity <= pwdata[CAPW-1:0];
        end
        if (r_state == ST_IDLE && i_in_valid) r_item <= i_in_data;
        if (r_state == ST_DONE && out_free) r_out <= r_res;
        r_res  <= n_res;
        r_scan <= n_scan;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign prdata      = paddr[2] ? 32'd0 : {{(32 - CAPW){1'b0}}, r_capacity};

    `LFU_ASSERT(a_accept_look, (r_state == ST_IDLE && i_in_valid) |=> (r_state == ST_LOOK))
    `LFU_ASSERT(a_unique_hit, $onehot0(match_vec))
    `LFU_ASSERT(a_victim_ready, (r_state == ST_EVICT) |-> cand[DEPTH].valid)
    `LFU_ASSERT(a_result_out, (r_state == ST_DONE && out_free) |=> o_out_valid)
    `LFU_ASSERT_RST(a_reset_idle, !i_rst_n |=> (r_state == ST_IDLE && !o_out_valid))
endmodule

### tb/tb_lfu_cache_table_unit.sv
// testbench for the lfu cache table: directed and random gets and puts, checked against a predictor
`timescale 1ns / 1ps
module tb_lfu_cache_table_unit import lfu_pkg::*; ();

    localparam int SLOTS     = 16;
    localparam int EVICT_LAT = SLOTS + 4;
    localparam logic [2:0] ADDR_CAPACITY = 3'd0;

    // lfu table predictor and queue of pending results
    class lfu_scoreboard;
        bit          slot_used[SLOTS];
        logic [31:0] slot_key[SLOTS];
        logic [31:0] slot_val[SLOTS];
        logic [31:0] slot_uses[SLOTS];
        int          slot_age[SLOTS];
        logic [4:0]  capacity;
        t_out_item   pending[$];
        int          errors;

        function void clear();
            foreach (slot_used[j]) slot_used[j] = 0;
            capacity = 5'd16;
            pending.delete();
            errors = 0;
        endfunction

        function void bump(int e);
            foreach (slot_used[j])
                if (slot_used[j] && slot_age[j] < slot_age[e]) slot_age[j]++;
            slot_age[e] = 0;
            if (slot_uses[e] != 32'hFFFF_FFFF) slot_uses[e]++;
        endfunction

        function void note_transfer(t_in_item it);
            t_out_item exp_res;
            int hit, held, victim, room, lim;
            hit = -1;
            held = 0;
            victim = -1;
            room = -1;
            lim = (capacity > SLOTS) ? SLOTS : int'(capacity);
            exp_res = '0;
            foreach (slot_used[j])
                if (slot_used[j]) begin
                    held++;
                    if (hit < 0 && slot_key[j] == it.lookup_key) hit = j;
                end
            exp_res.found = (hit >= 0);
            if (it.action == ACT_GET) begin
                if (hit >= 0) begin
                    bump(hit);
                    exp_res.read_value = slot_val[hit];
                end else begin
                    exp_res.read_value = -32'sd1;
                end
            end else if (lim != 0) begin
                if (hit >= 0) begin
                    slot_val[hit] = it.put_value;
                    bump(hit);
                end else begin
                    if (held >= lim) begin
                        foreach (slot_used[j])
                            if (slot_used[j] && (victim < 0 || slot_uses[j] < slot_uses[victim] ||
                                (slot_uses[j] == slot_uses[victim] &&
                                 slot_age[j] > slot_age[victim])))
                                victim = j;
                        if (victim >= 0) begin
                            foreach (slot_used[j])
                                if (slot_used[j] && slot_age[j] > slot_age[victim]) slot_age[j]--;
                            slot_used[victim] = 0;
                            exp_res.evicted = 1'b1;
                            exp_res.evicted_key = slot_key[victim];
                            room = victim;
                        end
                    end else begin
                        for (int j = SLOTS - 1; j >= 0; j--)
                            if (!slot_used[j]) room = j;
                    end
                    if (room >= 0) begin
                        foreach (slot_used[j])
                            if (slot_used[j]) slot_age[j]++;
                        slot_used[room] = 1;
                        slot_key[room] = it.lookup_key;
                        slot_val[room] = it.put_value;
                        slot_uses[room] = 1;
                        slot_age[room] = 0;
                    end
                end
            end
            pending = {pending, exp_res};
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.found !== want.found) begin
                $display("%0t: found expected %b got %b", $time, want.found, got.found);
                errors++;
            end
            if (got.read_value !== want.read_value) begin
                $display("%0t: read_value expected %h got %h", $time,
                         want.read_value, got.read_value);
                errors++;
            end
            if (got.evicted !== want.evicted) begin
                $display("%0t: evicted expected %b got %b", $time, want.evicted, got.evicted);
                errors++;
            end
            if (got.evicted_key !== want.evicted_key) begin
                $display("%0t: evicted_key expected %h got %h", $time,
                         want.evicted_key, got.evicted_key);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    lfu_scoreboard sb = new();
    bit            steady = 0;
    logic [31:0]   key_pool[24];

    lfu_cache_table_unit u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk)
        i_out_stall = !steady && ($urandom_range(99) < 24);

    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(logic act, logic [31:0] k, logic [31:0] v);
        while (!steady && $urandom_range(99) < 24) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data.action = act;
        i_in_data.lookup_key = k;
        i_in_data.put_value = v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_transfer(i_in_data);
        @(negedge i_clk);
    endtask

    task automatic write_capacity(logic [4:0] cap);
        i_in_valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (EVICT_LAT + 2) @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = ADDR_CAPACITY;
        pwdata = {27'd0, cap};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.capacity = cap;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic random_phase(logic [4:0] cap, int n, int pool_n);
        int idx;
        write_capacity(cap);
        foreach (key_pool[j]) key_pool[j] = $urandom;
        for (int i = 0; i < n; i++) begin
            steady = (i >= n / 3 && i < n / 3 + 60);
            idx = $urandom_range(pool_n - 1);
            if ($urandom_range(99) < 5)
                send_item($urandom_range(1), $urandom, $urandom);
            else
                send_item($urandom_range(1), key_pool[idx], $urandom);
        end
        steady = 0;
    endtask

    initial begin
        sb.clear();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // extremes, overwrite, hit and miss at reset capacity
        send_item(ACT_GET, 32'h8000_0000, 32'h0);
        send_item(ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(ACT_PUT, 32'h0, 32'hFFFF_FFFF);
        send_item(ACT_PUT, 32'hFFFF_FFFF, 32'h0);
        send_item(ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(ACT_GET, 32'h7FFF_FFFF, 32'h0);
        send_item(ACT_GET, 32'h0, 32'h0);
        send_item(ACT_GET, 32'hFFFF_FFFF, 32'h0);
        send_item(ACT_PUT, 32'h0, 32'h1234_5678);
        send_item(ACT_GET, 32'h0, 32'h0);
        send_item(ACT_GET, 32'h1, 32'h0);
        for (int i = 0; i < 13; i++)
            send_item(ACT_PUT, 32'h100 + i, $urandom);
        random_phase(5'd16, 250, 20);
        random_phase(5'd2, 150, 4);   // lowered below entries held
        random_phase(5'd0, 80, 4);
        random_phase(5'd1, 120, 3);
        random_phase(5'd31, 200, 22);
        random_phase(5'd5, 200, 8);
        random_phase(5'd17, 200, 20);
        random_phase(5'd3, 225, 5);
        i_in_valid = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (EVICT_LAT + 10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_lfu_cache_table_unit: PASS");
        else
            $display("tb_lfu_cache_table_unit: FAIL");
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_lfu_cache_table_unit: FAIL");
        $finish;
    end
endmodule

### lfu_cache_table_unit.f
+incdir+design
design/lfu_pkg.sv
design/lfu_cell.sv
design/lfu_cache_table_unit.sv
tb/tb_lfu_cache_table_unit.sv
